// ===== hw/rtl/lcpws_pkg.sv =====
// shared types, constants and helper functions of the led chain pulse width sequencer
package lcpws_pkg;

  // parameter defaults
  localparam int unsigned IMAGE_BYTES_DEF  = 96;
  localparam int unsigned IMAGE_COUNT_DEF  = 16;
  localparam int unsigned STOP_PERIODS_DEF = 50;

  // colour word layout
  localparam int unsigned COLOUR_BITS = 24;
  localparam int unsigned POS_W       = $clog2(COLOUR_BITS);

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COMPARE_W  = 16;

  localparam logic REG_ONE_COMPARE  = 1'b0;
  localparam logic REG_ZERO_COMPARE = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_START_COLOUR = 3'd1,
    CMD_START_IMAGE  = 3'd2,
    CMD_STOP         = 3'd3,
    CMD_WRITE_BYTE   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] color_value;
    logic [15:0] image_number;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
  } lcpws_in_t;

  typedef struct packed {
    logic [15:0] compare_value;
    logic        finished;
  } lcpws_out_t;

  // what a period produces, resolved in the output stage
  typedef enum logic [1:0] {
    PER_COLOUR_BIT,
    PER_IMAGE_BIT,
    PER_STOP,
    PER_FINISH
  } period_kind_e;

  typedef struct packed {
    period_kind_e kind;
    logic         colour_bit;
    logic [2:0]   bit_sel;
  } period_t;

  function automatic logic [7:0] flip_byte(input logic [7:0] x);
    logic [7:0] b;
    b = ((x & 8'hF0) >> 4) | ((x & 8'h0F) << 4);
    b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
    b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
    return b;
  endfunction

  function automatic logic [23:0] flip_colour(input logic [23:0] c);
    return {flip_byte(c[23:16]), flip_byte(c[15:8]), flip_byte(c[7:0])};
  endfunction

endpackage

// ===== hw/rtl/lcpws_store.sv =====
// image byte store with one write port and one registered read port
module lcpws_store #(
  parameter int unsigned DEPTH = 1536,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lcpws_seq.sv =====
// command decode, frame position state and store addressing
module lcpws_seq #(
  parameter int unsigned IMAGE_BYTES  = 96,
  parameter int unsigned IMAGE_COUNT  = 16,
  parameter int unsigned STOP_PERIODS = 50,
  localparam int unsigned ADDR_W = $clog2(IMAGE_COUNT * IMAGE_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  lcpws_pkg::lcpws_in_t  in_i,
  output logic                  period_valid_o,
  output lcpws_pkg::period_t    period_o,
  output logic                  mem_we_o,
  output logic [ADDR_W-1:0]     mem_waddr_o,
  output logic [7:0]            mem_wdata_o,
  output logic                  mem_re_o,
  output logic [ADDR_W-1:0]     mem_raddr_o
);
  import lcpws_pkg::*;

  localparam int unsigned FRAME_BITS = IMAGE_BYTES * 8;
  localparam int unsigned TOTAL      = FRAME_BITS + STOP_PERIODS;
  localparam int unsigned PI_W       = $clog2(TOTAL + 1);
  localparam int unsigned IMG_W      = (IMAGE_COUNT > 1) ? $clog2(IMAGE_COUNT) : 1;

  logic [PI_W-1:0]   pulse_index_q, pulse_index_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              busy_q, busy_d;
  logic              image_mode_q, image_mode_d;
  logic [23:0]       rev_colour_q, rev_colour_d;
  logic [ADDR_W-1:0] base_q, base_d;

  logic              img_ok, byte_ok, is_start, is_period;
  logic [ADDR_W-1:0] img_base;
  logic [PI_W-1:0]   cur_index;
  logic [POS_W-1:0]  cur_pos;
  logic [23:0]       cur_colour;
  logic              cur_mode;
  logic [ADDR_W-1:0] cur_base;
  logic              in_frame, in_total;

  assign img_ok   = 32'(in_i.image_number) < IMAGE_COUNT;
  assign byte_ok  = 32'(in_i.byte_index) < IMAGE_BYTES;
  assign img_base = ADDR_W'(in_i.image_number[IMG_W-1:0]) * ADDR_W'(IMAGE_BYTES);

  always_comb begin
    is_start  = 1'b0;
    is_period = 1'b0;
    unique case (in_i.cmd)
      CMD_TICK: begin
        is_period = busy_q;
      end
      CMD_START_COLOUR: begin
        is_start  = 1'b1;
        is_period = 1'b1;
      end
      CMD_START_IMAGE: begin
        is_start  = img_ok;
        is_period = img_ok;
      end
      default: begin
        is_start  = 1'b0;
        is_period = 1'b0;
      end
    endcase
  end

  // a start produces the first period of its own frame
  always_comb begin
    cur_index  = is_start ? '0 : pulse_index_q;
    cur_pos    = is_start ? '0 : pos_q;
    cur_colour = (in_i.cmd == CMD_START_COLOUR) ? flip_colour(in_i.color_value)
                                                : rev_colour_q;
    cur_mode   = is_start ? (in_i.cmd == CMD_START_IMAGE) : image_mode_q;
    cur_base   = (is_start && in_i.cmd == CMD_START_IMAGE) ? img_base : base_q;
  end

  assign in_frame = cur_index < PI_W'(FRAME_BITS);
  assign in_total = cur_index < PI_W'(TOTAL);

  always_comb begin
    period_o.colour_bit = cur_colour[cur_pos];
    period_o.bit_sel    = cur_index[2:0];
    if (!in_total) begin
      period_o.kind = PER_FINISH;
    end else if (!in_frame) begin
      period_o.kind = PER_STOP;
    end else if (cur_mode) begin
      period_o.kind = PER_IMAGE_BIT;
    end else begin
      period_o.kind = PER_COLOUR_BIT;
    end
  end

  assign period_valid_o = accept_i && is_period;

  assign mem_re_o    = accept_i && is_period && in_frame && cur_mode;
  assign mem_raddr_o = cur_base + ADDR_W'(cur_index >> 3);

  assign mem_we_o    = accept_i && (in_i.cmd == CMD_WRITE_BYTE) && img_ok && byte_ok;
  assign mem_waddr_o = img_base + ADDR_W'(in_i.byte_index);
  assign mem_wdata_o = in_i.byte_value;

  always_comb begin
    pulse_index_d = pulse_index_q;
    pos_d         = pos_q;
    busy_d        = busy_q;
    image_mode_d  = image_mode_q;
    rev_colour_d  = rev_colour_q;
    base_d        = base_q;
    if (accept_i) begin
      if (in_i.cmd == CMD_STOP) begin
        pulse_index_d = '0;
        busy_d        = 1'b0;
      end
      if (is_start) begin
        busy_d       = 1'b1;
        image_mode_d = cur_mode;
        rev_colour_d = cur_colour;
        base_d       = cur_base;
      end
      if (is_period) begin
        if (in_total) begin
          pulse_index_d = PI_W'(cur_index + 1'b1);
          pos_d = (cur_pos == POS_W'(COLOUR_BITS - 1)) ? '0 : POS_W'(cur_pos + 1'b1);
        end else begin
          pulse_index_d = cur_index;
          busy_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_index_q <= '0;
      pos_q         <= '0;
      busy_q        <= 1'b0;
      image_mode_q  <= 1'b0;
      rev_colour_q  <= '0;
      base_q        <= '0;
    end else begin
      pulse_index_q <= pulse_index_d;
      pos_q         <= pos_d;
      busy_q        <= busy_d;
      image_mode_q  <= image_mode_d;
      rev_colour_q  <= rev_colour_d;
      base_q        <= base_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(COLOUR_BITS))
    else $error("colour bit position out of range");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_index_q <= PI_W'(TOTAL))
    else $error("pulse index beyond frame and stop periods");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store written and read by one transaction");

endmodule

// ===== hw/rtl/lcpws_out.sv =====
// period holding stage, compare selection and output register
module lcpws_out (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    period_valid_i,
  input  lcpws_pkg::period_t      period_i,
  input  logic [7:0]              rdata_i,
  input  logic [15:0]             one_compare_i,
  input  logic [15:0]             zero_compare_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lcpws_pkg::lcpws_out_t   out_data_o
);
  import lcpws_pkg::*;

  logic       s2_valid_q;
  period_t    s2_q;
  logic       out_valid_q;
  lcpws_out_t out_data_q;
  lcpws_out_t result;
  logic       out_en, data_bit;

  assign out_en  = !out_valid_q || !out_stall_i;
  assign ready_o = !s2_valid_q || out_en;

  always_comb begin
    data_bit = (s2_q.kind == PER_IMAGE_BIT) ? rdata_i[s2_q.bit_sel] : s2_q.colour_bit;
    result.finished = (s2_q.kind == PER_FINISH);
    case (s2_q.kind) inside
      PER_COLOUR_BIT, PER_IMAGE_BIT: result.compare_value = data_bit ? one_compare_i
                                                                     : zero_compare_i;
      default:                       result.compare_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s2_valid_q <= period_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && period_valid_i) begin
      s2_q <= period_i;
    end
    if (out_en && s2_valid_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_finish_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.finished) |-> (out_data_q.compare_value == '0))
    else $error("finished transaction carries a non-zero compare");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result transaction changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (s2_valid_q && out_valid_q))
    else $error("input held off with a free stage");

endmodule

// ===== hw/rtl/led_chain_pulse_width_sequencer.sv =====
// top level of the led chain pulse width sequencer
//
// one input transaction per pwm timer period: a start (colour or stored image)
// begins a frame of IMAGE_BYTES*8 bits and returns the compare for its first
// bit, each tick while a frame runs returns the next compare, one_compare for
// a one bit and zero_compare for a zero bit, lsb first per image byte and msb
// first per colour byte; after the frame come STOP_PERIODS ticks at compare 0,
// then one transaction with finished set; a stop command aborts, write commands
// fill the image store; channels use valid/stall; registers one_compare (0x0)
// and zero_compare (0x4) sit on an apb-style port with pready tied high
// a result is registered in the holding stage, then in the output register
// throughput: one input transaction per cycle while in_stall_o is low; the
// command decode and store read run in the accepting cycle, the compare select
// in the next; a result waiting in the output register does not block input,
// the holding stage behind it takes one more; with both full and out_stall_i
// high, in_stall_o rises; reset clears frame state and both compare registers;
// image store contents are undefined until written
module led_chain_pulse_width_sequencer #(
  parameter int unsigned IMAGE_BYTES  = lcpws_pkg::IMAGE_BYTES_DEF,
  parameter int unsigned IMAGE_COUNT  = lcpws_pkg::IMAGE_COUNT_DEF,
  parameter int unsigned STOP_PERIODS = lcpws_pkg::STOP_PERIODS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lcpws_pkg::lcpws_in_t                in_data_i,
  // result transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lcpws_pkg::lcpws_out_t               out_data_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcpws_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lcpws_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lcpws_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import lcpws_pkg::*;

  localparam int unsigned DEPTH  = IMAGE_COUNT * IMAGE_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [COMPARE_W-1:0] one_compare_q, zero_compare_q;
  logic                 cfg_write;

  logic                 ready, accept;
  logic                 period_valid;
  period_t              period;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata, mem_rdata;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_compare_q  <= '0;
      zero_compare_q <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ONE_COMPARE:  one_compare_q  <= pwdata[COMPARE_W-1:0];
        REG_ZERO_COMPARE: zero_compare_q <= pwdata[COMPARE_W-1:0];
        default:          one_compare_q  <= one_compare_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ONE_COMPARE:  prdata = CFG_DATA_W'(one_compare_q);
      REG_ZERO_COMPARE: prdata = CFG_DATA_W'(zero_compare_q);
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- handshake
  // input is taken whenever the holding stage can move
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  // decode, frame state and store addressing
  lcpws_seq #(
    .IMAGE_BYTES  (IMAGE_BYTES),
    .IMAGE_COUNT  (IMAGE_COUNT),
    .STOP_PERIODS (STOP_PERIODS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_i           (in_data_i),
    .period_valid_o (period_valid),
    .period_o       (period),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr)
  );

  // image bytes, read data lands alongside the holding stage
  lcpws_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // compare selection and result register
  lcpws_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .period_valid_i (period_valid),
    .period_i       (period),
    .rdata_i        (mem_rdata),
    .one_compare_i  (one_compare_q),
    .zero_compare_i (zero_compare_q),
    .ready_o        (ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule
